FILE: rtl/drlp_pkg.sv
// Package for the date record line parser: transaction payload types,
// character codes, phase codes and character class functions.
// No dependencies.
package drlp_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } drlp_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  name_char;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic        status;
    } drlp_result_t;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [1:0] PH_NAME = 2'd0;
    localparam logic [1:0] PH_GAP  = 2'd1;
    localparam logic [1:0] PH_DATE = 2'd2;

    localparam logic KIND_NAME   = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    localparam logic [1:0] GROUP_YEAR  = 2'd0;
    localparam logic [1:0] GROUP_MONTH = 2'd1;
    localparam logic [1:0] GROUP_DAY   = 2'd2;
    localparam logic [2:0] YEAR_DIGITS = 3'd4;
    localparam logic [2:0] MD_DIGITS   = 3'd2;
    localparam logic [2:0] LEN_CAP     = 3'd5;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

endpackage

FILE: rtl/date_record_line_parser_core.sv
// Top level of the date record line parser: input register, per-character
// parse logic and result register. Depends on drlp_pkg.
//
// Usage: feed one character of a line "name: Y-M-D" per transaction on the
// item channel, with line_end set on the last character. Every name
// character before the first colon comes back as a result with kind 0.
// The last character of the line returns one record (kind 1) with year,
// month, day and status (0 valid, 1 bad; the date fields are 0 when bad).
// Other characters return nothing.
// Throughput: one character per cycle while no result is stalled, set by
// the combinational parse logic between the input and result registers.
// A character waits in the input register until the result register is
// free; its result is then registered in the result register.
// Stall: when result_stall holds a waiting result, the input register still
// takes one more character; item_stall rises only when both registers are
// full. A stalled result holds its value.
// Reset: rst_n clears both registers and puts the parser at the start of
// a line (name phase, accumulators zero). It also returns there after
// every last character.
module date_record_line_parser_core
    import drlp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  drlp_item_t   item,
    output logic         result_valid,
    input  logic         result_stall,
    output drlp_result_t result
);

    logic         in_valid_reg;
    drlp_item_t   in_data_reg;
    logic         out_valid_reg;
    drlp_result_t out_data_reg;

    logic [1:0]  phase_reg,     phase_next;
    logic [1:0]  group_idx_reg, group_idx_next;
    logic [2:0]  group_len_reg, group_len_next;
    logic [13:0] year_reg,      year_next;
    logic [6:0]  month_reg,     month_next;
    logic [6:0]  day_reg,       day_next;
    logic        bad_reg,       bad_next;

    logic         out_free;
    logic         fire;
    logic         emit;
    drlp_result_t res_comb;

    assign out_free   = !out_valid_reg || !result_stall;
    assign fire       = in_valid_reg && out_free;
    assign item_stall = in_valid_reg && !out_free;

    always_comb
    begin
        logic [7:0]  c;
        logic [3:0]  digit;
        logic        take_digit;
        logic [1:0]  gi;
        logic [2:0]  gl;
        logic [2:0]  gl_inc;
        logic [2:0]  limit;
        logic        echo;
        logic        ok;

        c     = in_data_reg.char_code;
        digit = c[3:0];
        take_digit = 1'b0;
        gi    = group_idx_reg;
        gl    = group_len_reg;
        echo  = 1'b0;

        phase_next     = phase_reg;
        group_idx_next = group_idx_reg;
        group_len_next = group_len_reg;
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        bad_next       = bad_reg;

        unique case (phase_reg)
            PH_NAME:
            begin
                if (c == CHAR_COLON)
                begin
                    phase_next = PH_GAP;
                end
                else
                begin
                    if (!(is_alpha(c) || is_digit(c) || is_space(c)))
                        bad_next = 1'b1;
                    echo = 1'b1;
                end
            end
            PH_GAP:
            begin
                if (is_digit(c))
                begin
                    phase_next = PH_DATE;
                    gi = GROUP_YEAR;
                    gl = 3'd0;
                    take_digit = 1'b1;
                end
                else if (!(is_space(c) || c == CHAR_COLON || c == CHAR_DASH))
                begin
                    bad_next = 1'b1;
                end
            end
            PH_DATE:
            begin
                if (is_digit(c))
                begin
                    take_digit = 1'b1;
                end
                else if (c == CHAR_DASH)
                begin
                    if (group_len_reg == 3'd0 || group_idx_reg >= GROUP_DAY)
                        bad_next = 1'b1;
                    else
                    begin
                        group_idx_next = group_idx_reg + 2'd1;
                        group_len_next = 3'd0;
                    end
                end
                else
                begin
                    bad_next = 1'b1;
                end
            end
            default:
            begin
                bad_next = 1'b1;
            end
        endcase

        // Count the digit (saturating) and fold it into the current group.
        gl_inc = (gl < LEN_CAP) ? gl + 3'd1 : gl;
        limit  = (gi == GROUP_YEAR) ? YEAR_DIGITS : MD_DIGITS;
        if (take_digit)
        begin
            group_idx_next = gi;
            group_len_next = gl_inc;
            if (gl_inc > limit)
                bad_next = 1'b1;
            else if (gi == GROUP_YEAR)
                year_next = (year_reg << 3) + (year_reg << 1) + {10'd0, digit};
            else if (gi == GROUP_MONTH)
                month_next = (month_reg << 3) + (month_reg << 1) + {3'd0, digit};
            else
                day_next = (day_reg << 3) + (day_reg << 1) + {3'd0, digit};
        end

        ok = !bad_next && phase_next == PH_DATE && group_idx_next == GROUP_DAY
             && group_len_next != 3'd0;

        res_comb = '0;
        emit     = in_data_reg.line_end || echo;
        if (in_data_reg.line_end)
        begin
            res_comb.kind = KIND_RECORD;
            if (ok)
            begin
                res_comb.year   = year_next;
                res_comb.month  = month_next;
                res_comb.day    = day_next;
                res_comb.status = STATUS_OK;
            end
            else
            begin
                res_comb.status = STATUS_BAD;
            end
            // Back to the start of a line.
            phase_next     = PH_NAME;
            group_idx_next = 2'd0;
            group_len_next = 3'd0;
            year_next      = '0;
            month_next     = '0;
            day_next       = '0;
            bad_next       = 1'b0;
        end
        else
        begin
            res_comb.kind      = KIND_NAME;
            res_comb.name_char = c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_NAME;
            group_idx_reg <= 2'd0;
            group_len_reg <= 3'd0;
            year_reg      <= '0;
            month_reg     <= '0;
            day_reg       <= '0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            if (!item_stall)
                in_valid_reg <= item_valid;
            if (out_free)
                out_valid_reg <= fire && emit;
            if (fire)
            begin
                phase_reg     <= phase_next;
                group_idx_reg <= group_idx_next;
                group_len_reg <= group_len_next;
                year_reg      <= year_next;
                month_reg     <= month_next;
                day_reg       <= day_next;
                bad_reg       <= bad_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
            in_data_reg <= item;
        if (fire && emit)
            out_data_reg <= res_comb;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

FILE: rtl/drlp_checker.sv
// Port-level checks for date_record_line_parser_core, bound to the top
// level. Depends on drlp_pkg.
module drlp_checker
    import drlp_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         item_valid,
    input logic         item_stall,
    input drlp_item_t   item,
    input logic         result_valid,
    input logic         result_stall,
    input drlp_result_t result
);

    // Hold a stalled result.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // Hold a stalled input transaction.
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("stalled item changed");

    a_echo_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_NAME |->
        result.year == 14'd0 && result.month == 7'd0 && result.day == 7'd0 &&
        result.status == STATUS_OK)
        else $error("name echo carries date fields");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_RECORD && result.status == STATUS_BAD |->
        result.year == 14'd0 && result.month == 7'd0 && result.day == 7'd0 &&
        result.name_char == 8'd0)
        else $error("bad record carries values");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_RECORD |->
        result.year <= 14'd9999 && result.month <= 7'd99 && result.day <= 7'd99)
        else $error("date group out of digit range");

endmodule

bind date_record_line_parser_core drlp_checker u_drlp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

FILE: dv/tb_date_record_line_parser_core.sv
// Testbench for date_record_line_parser_core: drives character lines with random
// gaps and result stalls, predicts name echoes and date records, and checks them.
// Depends on drlp_pkg and the core RTL.
module tb_date_record_line_parser_core
    import drlp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET    = 1350;
    localparam int WATCHDOG_LIMIT = 200;
    localparam int DRAIN_CYCLES   = 8;

    class date_line_scoreboard;
        logic [1:0]  phase;
        logic [1:0]  group_idx;
        logic [2:0]  digits_in_group;
        logic [13:0] year_sum;
        logic [6:0]  month_sum;
        logic [6:0]  day_sum;
        logic        line_bad;
        drlp_result_t awaited_results[$];
        int          mismatch_count;

        function new();
            clear_line();
            mismatch_count = 0;
        endfunction

        function void clear_line();
            phase           = PH_NAME;
            group_idx       = GROUP_YEAR;
            digits_in_group = '0;
            year_sum        = '0;
            month_sum       = '0;
            day_sum         = '0;
            line_bad        = 1'b0;
        endfunction

        function logic digit_char(logic [7:0] c);
            return c >= 8'h30 && c <= 8'h39;
        endfunction

        function logic blank_char(logic [7:0] c);
            return c == CHAR_SPACE || (c >= 8'd9 && c <= 8'd13);
        endfunction

        function logic letter_char(logic [7:0] c);
            return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        endfunction

        function void take_digit(logic [7:0] c);
            logic [3:0] d;
            d = 4'(c - 8'h30);
            if (digits_in_group < LEN_CAP)
                digits_in_group++;
            // drop digits past the group width and mark the line
            if (digits_in_group > ((group_idx == GROUP_YEAR) ? YEAR_DIGITS : MD_DIGITS))
                line_bad = 1'b1;
            else if (group_idx == GROUP_YEAR)
                year_sum = year_sum * 14'd10 + 14'(d);
            else if (group_idx == GROUP_DAY)
                day_sum = day_sum * 7'd10 + 7'(d);
            else
                month_sum = month_sum * 7'd10 + 7'(d);
        endfunction

        function void note_char(drlp_item_t it);
            logic [7:0]   c;
            logic         echo;
            logic         ok;
            drlp_result_t r;
            c    = it.char_code;
            echo = 1'b0;
            case (phase)
                PH_NAME:
                begin
                    if (c == CHAR_COLON)
                        phase = PH_GAP;
                    else
                    begin
                        if (!(letter_char(c) || digit_char(c) || blank_char(c)))
                            line_bad = 1'b1;
                        echo = 1'b1;
                    end
                end
                PH_GAP:
                begin
                    if (digit_char(c))
                    begin
                        phase           = PH_DATE;
                        group_idx       = GROUP_YEAR;
                        digits_in_group = '0;
                        take_digit(c);
                    end
                    else if (!(blank_char(c) || c == CHAR_COLON || c == CHAR_DASH))
                        line_bad = 1'b1;
                end
                default:
                begin
                    if (digit_char(c))
                        take_digit(c);
                    else if (c == CHAR_DASH)
                    begin
                        if (digits_in_group == 0 || group_idx >= GROUP_DAY)
                            line_bad = 1'b1;
                        else
                        begin
                            group_idx++;
                            digits_in_group = '0;
                        end
                    end
                    else
                        line_bad = 1'b1;
                end
            endcase

            r = '0;
            if (it.line_end)
            begin
                ok = !line_bad && phase == PH_DATE && group_idx == GROUP_DAY &&
                     digits_in_group != 0;
                r.kind = KIND_RECORD;
                if (ok)
                begin
                    r.year   = year_sum;
                    r.month  = month_sum;
                    r.day    = day_sum;
                    r.status = STATUS_OK;
                end
                else
                    r.status = STATUS_BAD;
                awaited_results = {awaited_results, r};
                clear_line();
            end
            else if (echo)
            begin
                r.kind      = KIND_NAME;
                r.name_char = c;
                awaited_results = {awaited_results, r};
            end
        endfunction

        function void compare_field(string fname, logic [13:0] want_v, logic [13:0] got_v);
            if (want_v !== got_v)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, fname, want_v, got_v);
                mismatch_count++;
            end
        endfunction

        function void check_result(drlp_result_t got);
            drlp_result_t want;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, got);
                mismatch_count++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("kind", 14'(want.kind), 14'(got.kind));
            compare_field("name_char", 14'(want.name_char), 14'(got.name_char));
            compare_field("year", want.year, got.year);
            compare_field("month", 14'(want.month), 14'(got.month));
            compare_field("day", 14'(want.day), 14'(got.day));
            compare_field("status", 14'(want.status), 14'(got.status));
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         item_valid;
    logic         item_stall;
    drlp_item_t   item;
    logic         result_valid;
    logic         result_stall;
    drlp_result_t result;

    date_line_scoreboard scoreboard = new();
    bit calm;
    int sent_chars;
    int idle_cycles = 0;

    date_record_line_parser_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int wait_draw();
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic logic [7:0] pick_from(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic logic [7:0] pick_name_char();
        int r;
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(65, 90));
            1: return 8'($urandom_range(97, 122));
            2: return 8'($urandom_range(48, 57));
            default:
            begin
                r = $urandom_range(8, 13);
                return (r == 8) ? CHAR_SPACE : 8'(r);
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'($urandom_range(48, 57));
    endfunction

    task automatic send_char(drlp_item_t it);
        int gap;
        gap = wait_draw();
        repeat (gap)
        begin
            @(negedge clk);
            item_valid = 1'b0;
        end
        @(negedge clk);
        item_valid = 1'b1;
        item       = it;
        do
            @(posedge clk);
        while (item_stall);
        scoreboard.note_char(it);
        sent_chars++;
    endtask

    task automatic send_line(logic [7:0] chars[$]);
        drlp_item_t it;
        for (int i = 0; i < chars.size(); i++)
        begin
            it.char_code = chars[i];
            it.line_end  = (i == chars.size() - 1);
            send_char(it);
        end
    endtask

    task automatic send_text(string s);
        logic [7:0] q[$];
        for (int i = 0; i < s.len(); i++)
            q = {q, s[i]};
        send_line(q);
    endtask

    task automatic random_line();
        logic [7:0] q[$];
        int         style;
        style = $urandom_range(0, 9);
        if (style < 7)
        begin
            repeat ($urandom_range(0, 5)) q = {q, pick_name_char()};
            q = {q, CHAR_COLON};
            repeat ($urandom_range(0, 2)) q = {q, pick_from(" \t:-")};
            repeat ($urandom_range(1, 4)) q = {q, pick_digit()};
            q = {q, CHAR_DASH};
            repeat ($urandom_range(1, 2)) q = {q, pick_digit()};
            q = {q, CHAR_DASH};
            repeat ($urandom_range(1, 2)) q = {q, pick_digit()};
            // break a share of the well-formed lines
            if (style >= 5)
            begin
                case ($urandom_range(0, 3))
                    0: q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
                    1: q.insert($urandom_range(0, q.size() - 1), pick_digit());
                    2: q.delete($urandom_range(0, q.size() - 1));
                    default:
                    begin
                        q = {q, CHAR_DASH};
                        q = {q, pick_digit()};
                    end
                endcase
            end
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                q = {q, ($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                              : pick_from(":-09 a"))};
        end
        send_line(q);
    endtask

    // result side: random stall, then take one transaction
    initial
    begin
        int n;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = wait_draw();
            repeat (n)
            begin
                @(negedge clk);
                result_stall = 1'b1;
            end
            @(negedge clk);
            result_stall = 1'b0;
            do
                @(posedge clk);
            while (!result_valid);
            scoreboard.check_result(result);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        calm       = 1'b0;
        sent_chars = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // maximum date with a busy gap, bad name bytes ending on a colon,
        // line ending inside the name, stray letter after the colon
        send_text("z0 :\t-:9999-99-99");
        send_line({8'h00, 8'hFF, CHAR_COLON});
        send_text("x");
        send_text(":a");

        while (sent_chars < ITEM_TARGET)
        begin
            if ($urandom_range(0, 7) == 0)
                calm = !calm;
            random_line();
        end
        @(negedge clk);
        item_valid = 1'b0;

        while (scoreboard.awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (scoreboard.mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
